// ===== sv/svt_pkg.sv =====
`timescale 1ns / 1ps

package svt_pkg;

   localparam int TableDepth = 16;
   localparam int CountWidth = $clog2(TableDepth + 1);
   localparam int ValueWidth = 32;
   localparam int EntryCountWidth = 5;

   typedef enum logic [1:0] {
      StInserted = 2'd0,
      StFull     = 2'd1,
      StDeleted  = 2'd2,
      StNotFound = 2'd3
   } status_type;

   typedef enum logic {
      ModeInsert = 1'b0,
      ModeDelete = 1'b1
   } mode_type;

   typedef struct packed {
      logic                         mode;
      logic signed [ValueWidth-1:0] value;
   } req_type;

   typedef struct packed {
      status_type                   status;
      logic [EntryCountWidth-1:0]   entry_count;
      logic signed [ValueWidth-1:0] smallest_value;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic                         apply;
      logic                         del;
      logic signed [ValueWidth-1:0] value;
   } cmd_type;

endpackage

// ===== sv/svt_cell.sv =====
`timescale 1ns / 1ps

module svt_cell
   import svt_pkg::*;
(
   input  logic                         clock,
   input  cmd_type                      cmd,
   input  logic                         valid,
   input  logic                         left_le,
   input  logic signed [ValueWidth-1:0] left_value,
   input  logic signed [ValueWidth-1:0] right_value,
   output logic                         le,
   output logic                         eq,
   output logic signed [ValueWidth-1:0] value_in,
   output logic signed [ValueWidth-1:0] stored_value
);

   logic signed [ValueWidth-1:0] value_ff;
   logic                         ge;

   assign le = valid && ($signed(value_ff) <= $signed(cmd.value));
   assign ge = valid && ($signed(value_ff) >= $signed(cmd.value));
   assign eq = valid && (value_ff == cmd.value);

   assign stored_value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.apply) begin
         if (!cmd.del) begin
            // insert: slot after the last entry not above the value, larger ones move up
            if (!le) begin
               value_in = left_le ? cmd.value : left_value;
            end
         end else if (ge || !valid) begin
            // delete: from the first match on, entries move down
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== sv/sorted_value_table_unit.sv =====
`timescale 1ns / 1ps

// sorted value table: up to 16 signed 32-bit entries held in ascending order
// request beat: req_payload.mode selects insert (0) or delete of the first equal entry (1),
//    req_payload.value is the operand
// response beat: rsp_payload.status, entry_count after the step, and the smallest entry
//    (zero when the table is empty); exactly one response per request
// every cell compares the operand in parallel and takes its own entry, the operand or its left
//    or right neighbor's entry, so the whole table updates in the cycle the request is accepted
// the response is registered and is valid in the cycle after the request beat
// throughput: one request per cycle while responses are taken
// a full response register with rsp_ready low holds req_ready low; the table does not change
//    until the pending response is taken or taken in the same cycle
// reset: entry count cleared, no response pending; entry storage is not cleared
//    since only entries below the count are ever read
module sorted_value_table_unit
   import svt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff, rsp_payload_in;

   logic                         accept;
   logic                         is_del;
   logic                         full;
   logic                         found;
   cmd_type                      cmd;
   logic [TableDepth-1:0]        le_vec;
   logic [TableDepth-1:0]        eq_vec;
   logic [TableDepth-1:0]        valid_vec;
   logic signed [ValueWidth-1:0] next_value [TableDepth];
   logic signed [ValueWidth-1:0] cur_value  [TableDepth];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_del    = (req_payload.mode == ModeDelete);
   assign full      = (count_ff == CountWidth'(TableDepth));
   assign found     = |eq_vec;

   assign cmd.apply = accept && (is_del ? found : !full);
   assign cmd.del   = is_del;
   assign cmd.value = req_payload.value;

   genvar g;
   generate
      for (g = 0; g < TableDepth; g++) begin : g_cell
         logic                         left_le;
         logic signed [ValueWidth-1:0] left_value;
         logic signed [ValueWidth-1:0] right_value;

         assign valid_vec[g] = (CountWidth'(g) < count_ff);

         if (g == 0) begin : g_first
            assign left_le    = 1'b1;
            assign left_value = '0;
         end else begin : g_mid
            assign left_le    = le_vec[g-1];
            assign left_value = cur_value[g-1];
         end

         if (g == TableDepth - 1) begin : g_last
            assign right_value = '0;
         end else begin : g_inner
            assign right_value = cur_value[g+1];
         end

         svt_cell u_cell (
            .clock        (clock),
            .cmd          (cmd),
            .valid        (valid_vec[g]),
            .left_le      (left_le),
            .left_value   (left_value),
            .right_value  (right_value),
            .le           (le_vec[g]),
            .eq           (eq_vec[g]),
            .value_in     (next_value[g]),
            .stored_value (cur_value[g])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (cmd.apply) begin
         count_in = is_del ? count_ff - CountWidth'(1) : count_ff + CountWidth'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
      end

      rsp_payload_in = rsp_payload_ff;
      if (accept) begin
         if (is_del) begin
            rsp_payload_in.status = found ? StDeleted : StNotFound;
         end else begin
            rsp_payload_in.status = full ? StFull : StInserted;
         end
         rsp_payload_in.entry_count    = EntryCountWidth'(count_in);
         rsp_payload_in.smallest_value = (count_in != '0) ? next_value[0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== tb/tb_sorted_value_table_unit.sv =====
`timescale 1ns / 1ps

module tb_sorted_value_table_unit;
   import svt_pkg::*;

   localparam int ClockPeriod = 12;
   localparam int ResetCycles = 9;
   localparam int CycleLimit = 300000;
   localparam int RandomPerPhase = 450;
   localparam int ReportCap = 50;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // table shadow, updated on every accepted request beat
   logic signed [ValueWidth-1:0] table_vals[TableDepth];
   int                           table_count = 0;

   // multiset of stored values as seen while building the stimulus
   logic signed [ValueWidth-1:0] live_vals[$];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int cycle_count = 0;

   logic signed [ValueWidth-1:0] corner_vals[6] = '{
      32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000,
      32'shffff_ffff, 32'sh8000_0001, 32'sh7fff_fffe
   };

   int phase_send_idle[4] = '{0, 82, 0, 23};
   int phase_stall[4] = '{0, 0, 82, 23};

   sorted_value_table_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      if (error_count < ReportCap) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   function automatic rsp_type apply_to_table(req_type item);
      rsp_type                      result;
      logic signed [ValueWidth-1:0] operand;
      int                           pos;
      int                           k;
      result = '0;
      operand = item.value;
      if (item.mode == ModeInsert) begin
         if (table_count >= TableDepth) begin
            result.status = StFull;
         end else begin
            pos = 0;
            while (pos < table_count && table_vals[pos] <= operand) pos++;
            for (k = table_count; k > pos; k--) table_vals[k] = table_vals[k - 1];
            table_vals[pos] = operand;
            table_count++;
            result.status = StInserted;
         end
      end else begin
         pos = -1;
         for (k = 0; k < table_count; k++) begin
            if (pos < 0 && table_vals[k] == operand) pos = k;
         end
         if (pos >= 0) begin
            for (k = pos; k < table_count - 1; k++) table_vals[k] = table_vals[k + 1];
            table_count--;
            result.status = StDeleted;
         end else begin
            result.status = StNotFound;
         end
      end
      result.entry_count = EntryCountWidth'(table_count);
      result.smallest_value = (table_count > 0) ? table_vals[0] : '0;
      return result;
   endfunction

   task automatic queue_req(mode_type mode, logic signed [ValueWidth-1:0] value);
      req_type item;
      int      k;
      int      hit;
      item.mode = mode;
      item.value = value;
      pending_reqs.push_back(item);
      if (mode == ModeInsert) begin
         if (live_vals.size() < TableDepth) live_vals.push_back(value);
      end else begin
         hit = -1;
         for (k = 0; k < live_vals.size(); k++) begin
            if (hit < 0 && live_vals[k] == value) hit = k;
         end
         if (hit >= 0) live_vals.delete(hit);
      end
   endtask

   function automatic logic signed [ValueWidth-1:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) return $urandom_range(12) - 6;
      else if (sel < 55) return corner_vals[$urandom_range(5)];
      else return $urandom;
   endfunction

   task automatic add_random(int n);
      int                           insert_pct;
      int                           i;
      logic signed [ValueWidth-1:0] v;
      insert_pct = 50;
      for (i = 0; i < n; i++) begin
         // swing between filling and draining so full and empty both occur
         if (i % 50 == 0) begin
            case ($urandom_range(2))
               0: insert_pct = 20;
               1: insert_pct = 50;
               default: insert_pct = 85;
            endcase
         end
         if ($urandom_range(99) < insert_pct) begin
            queue_req(ModeInsert, pick_value());
         end else begin
            if (live_vals.size() > 0 && $urandom_range(99) < 70) begin
               v = live_vals[$urandom_range(live_vals.size() - 1)];
            end else begin
               v = pick_value();
            end
            queue_req(ModeDelete, v);
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(apply_to_table(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.status !== want.status) begin
                  report_mismatch($sformatf("status got %0d want %0d",
                     rsp_payload.status, want.status));
               end
               if (rsp_payload.entry_count !== want.entry_count) begin
                  report_mismatch($sformatf("entry_count got %0d want %0d",
                     rsp_payload.entry_count, want.entry_count));
               end
               if (rsp_payload.smallest_value !== want.smallest_value) begin
                  report_mismatch($sformatf("smallest_value got %0d want %0d",
                     rsp_payload.smallest_value, want.smallest_value));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int i;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // directed: empty delete, extremes, duplicates, fill past full, deletes of present and absent values
      queue_req(ModeDelete, 32'sh0000_0000);
      queue_req(ModeInsert, 32'sh7fff_ffff);
      queue_req(ModeInsert, 32'sh8000_0000);
      queue_req(ModeInsert, 32'sh0000_0000);
      queue_req(ModeInsert, 32'sh0000_0000);
      queue_req(ModeInsert, 32'shffff_ffff);
      queue_req(ModeInsert, 32'sh5555_5555);
      queue_req(ModeInsert, 32'shaaaa_aaaa);
      for (i = 0; i < 8; i++) queue_req(ModeInsert, i * 1000 - 3500);
      queue_req(ModeInsert, 32'sh0000_0001);
      queue_req(ModeInsert, 32'sh8000_0000);
      queue_req(ModeDelete, 32'sh0000_3039);
      queue_req(ModeDelete, 32'sh8000_0000);
      queue_req(ModeDelete, 32'sh0000_0000);
      queue_req(ModeDelete, 32'sh7fff_ffff);
      queue_req(ModeDelete, 32'sh0000_0000);
      queue_req(ModeInsert, 32'sh8000_0000);
      wait_drained();

      for (i = 0; i < 4; i++) begin
         send_idle_pct = phase_send_idle[i];
         stall_pct = phase_stall[i];
         add_random(RandomPerPhase);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
